// ===== rtl/cscan_pkg.sv =====
// Shared types and constants for the C-SCAN request scheduler.
`default_nettype none

package cscan_pkg;

   localparam int CFG_W     = 11;   // disk_tracks register width
   localparam int SEEK_W    = 16;   // seek total width
   localparam int COUNT_W   = 6;    // request count width
   localparam logic [CFG_W-1:0] DISK_TRACKS_RESET = 11'd200;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_INS_READ,
      DP_INS_SHIFT,
      DP_INS_PLACE,
      DP_SCAN_FIRST,
      DP_SCAN_NEXT,
      DP_MID_PTR,
      DP_MID_N,
      DP_SEG1_SETUP,
      DP_SEG_READ,
      DP_VISIT_REQ,
      DP_VISIT_END1,
      DP_VISIT_END2
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic ins_gt;
      logic ptr_one;
      logic scan_gt;
      logic scan_end;
      logic left_zero;
      logic left_one;
      logic seg2_empty;
      logic out_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_START,
      ST_INS_CMP,
      ST_INS_TAIL,
      ST_SCAN_START,
      ST_SCAN_CMP,
      ST_SEG1_SETUP,
      ST_SEG1_RD,
      ST_SEG1_EMIT,
      ST_END1,
      ST_END2,
      ST_SEG2_RD,
      ST_SEG2_EMIT
   } ctrl_state_type;

endpackage

`default_nettype wire

// ===== rtl/cscan_ifs.sv =====
// Channel interfaces: request, response and register write.
`default_nettype none

interface cscan_req_if #(parameter int TRACK_BITS = 10);
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [TRACK_BITS-1:0] track;
   logic [TRACK_BITS-1:0] head_start;
   logic                  go_right;

   modport source (output valid, cmd, track, head_start, go_right, input ready);
   modport sink   (input valid, cmd, track, head_start, go_right, output ready);
endinterface

interface cscan_rsp_if #(parameter int TRACK_BITS = 10);
   logic                           valid;
   logic                           ready;
   logic [TRACK_BITS-1:0]          served_track;
   logic                           is_end_track;
   logic [cscan_pkg::SEEK_W-1:0]   seek_total;
   logic [cscan_pkg::COUNT_W-1:0]  request_count;
   logic                           last;

   modport source (output valid, served_track, is_end_track, seek_total, request_count, last,
                   input ready);
   modport sink   (input valid, served_track, is_end_track, seek_total, request_count, last,
                   output ready);
endinterface

interface cscan_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cscan_pkg::CFG_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/cscan_disk_request_scheduler_unit.sv =====
// Top level of the C-SCAN disk request scheduler.
//
//   channel   dir   transfer moves
//   req_chan  in    cmd, track, head_start, go_right (load one request or start a run)
//   rsp_chan  out   served_track, is_end_track, seek_total, request_count, last
//   csr_chan  in    wdata: disk_tracks (11 bits, reset 200)
//
// A load into an empty or full store needs no store read; otherwise each stored entry larger
// than the new track is shifted up one at a time through the single write and registered read port.
// A run holds the sequencer through the pivot search (no compares when the store is empty) and
// every visit: each request visit needs a store read and then a result register load, and the
// final result then leaves the register.
// Reset is synchronous; it empties the store and sets disk_tracks to 200.
// A stalled rsp_chan holds the sequencer in place; req_chan is taken only between items.
`default_nettype none

module cscan_disk_request_scheduler_unit #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cscan_req_if.sink   req_chan,
   cscan_rsp_if.source rsp_chan,
   cscan_csr_if.sink   csr_chan
);

   cscan_pkg::dp_cmd_type    dp_cmd;
   cscan_pkg::dp_status_type dp_status;
   logic                     req_ready;

   cscan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_ready),
      .status    (dp_status),
      .dp_cmd    (dp_cmd)
   );

   cscan_dpath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .TRACK_BITS   (TRACK_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_chan.cmd),
      .req_track      (req_chan.track),
      .req_head_start (req_chan.head_start),
      .req_go_right   (req_chan.go_right),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .dp_cmd         (dp_cmd),
      .status         (dp_status)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire

// ===== rtl/cscan_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cscan_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cscan_ctrl.sv =====
// Sequencer for insertion, pivot search and the C-SCAN visit order.
`default_nettype none

module cscan_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_cmd,
   output logic                          req_ready,
   input  wire cscan_pkg::dp_status_type status,
   output cscan_pkg::dp_cmd_type         dp_cmd
);

   cscan_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cscan_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      dp_cmd.op   = cscan_pkg::DP_NOP;
      dp_cmd.last = 1'b0;
      case (state_ff)
         cscan_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = cscan_pkg::DP_LATCH;
               state_in  = (req_cmd == cscan_pkg::CMD_RUN) ? cscan_pkg::ST_SCAN_START
                                                            : cscan_pkg::ST_INS_START;
            end
         end
         cscan_pkg::ST_INS_START: begin
            if (status.cnt_full) begin
               state_in = cscan_pkg::ST_IDLE;
            end else if (status.cnt_zero) begin
               dp_cmd.op = cscan_pkg::DP_INS_PLACE;
               state_in  = cscan_pkg::ST_IDLE;
            end else begin
               dp_cmd.op = cscan_pkg::DP_INS_READ;
               state_in  = cscan_pkg::ST_INS_CMP;
            end
         end
         cscan_pkg::ST_INS_CMP: begin
            // shift one entry up per cycle while the entry below is larger
            if (status.ins_gt) begin
               dp_cmd.op = cscan_pkg::DP_INS_SHIFT;
               state_in  = status.ptr_one ? cscan_pkg::ST_INS_TAIL : cscan_pkg::ST_INS_CMP;
            end else begin
               dp_cmd.op = cscan_pkg::DP_INS_PLACE;
               state_in  = cscan_pkg::ST_IDLE;
            end
         end
         cscan_pkg::ST_INS_TAIL: begin
            dp_cmd.op = cscan_pkg::DP_INS_PLACE;
            state_in  = cscan_pkg::ST_IDLE;
         end
         cscan_pkg::ST_SCAN_START: begin
            if (status.cnt_zero) begin
               dp_cmd.op = cscan_pkg::DP_MID_N;
               state_in  = cscan_pkg::ST_SEG1_SETUP;
            end else begin
               dp_cmd.op = cscan_pkg::DP_SCAN_FIRST;
               state_in  = cscan_pkg::ST_SCAN_CMP;
            end
         end
         cscan_pkg::ST_SCAN_CMP: begin
            if (status.scan_gt) begin
               dp_cmd.op = cscan_pkg::DP_MID_PTR;
               state_in  = cscan_pkg::ST_SEG1_SETUP;
            end else if (status.scan_end) begin
               dp_cmd.op = cscan_pkg::DP_MID_N;
               state_in  = cscan_pkg::ST_SEG1_SETUP;
            end else begin
               dp_cmd.op = cscan_pkg::DP_SCAN_NEXT;
            end
         end
         cscan_pkg::ST_SEG1_SETUP: begin
            dp_cmd.op = cscan_pkg::DP_SEG1_SETUP;
            state_in  = cscan_pkg::ST_SEG1_RD;
         end
         cscan_pkg::ST_SEG1_RD: begin
            if (status.left_zero) begin
               state_in = cscan_pkg::ST_END1;
            end else begin
               dp_cmd.op = cscan_pkg::DP_SEG_READ;
               state_in  = cscan_pkg::ST_SEG1_EMIT;
            end
         end
         cscan_pkg::ST_SEG1_EMIT: begin
            if (status.out_free) begin
               dp_cmd.op = cscan_pkg::DP_VISIT_REQ;
               state_in  = cscan_pkg::ST_SEG1_RD;
            end
         end
         cscan_pkg::ST_END1: begin
            if (status.out_free) begin
               dp_cmd.op = cscan_pkg::DP_VISIT_END1;
               state_in  = cscan_pkg::ST_END2;
            end
         end
         cscan_pkg::ST_END2: begin
            if (status.out_free) begin
               dp_cmd.op   = cscan_pkg::DP_VISIT_END2;
               dp_cmd.last = status.seg2_empty;
               state_in    = status.seg2_empty ? cscan_pkg::ST_IDLE : cscan_pkg::ST_SEG2_RD;
            end
         end
         cscan_pkg::ST_SEG2_RD: begin
            dp_cmd.op = cscan_pkg::DP_SEG_READ;
            state_in  = cscan_pkg::ST_SEG2_EMIT;
         end
         cscan_pkg::ST_SEG2_EMIT: begin
            if (status.out_free) begin
               dp_cmd.op   = cscan_pkg::DP_VISIT_REQ;
               dp_cmd.last = status.left_one;
               state_in    = status.left_one ? cscan_pkg::ST_IDLE : cscan_pkg::ST_SEG2_RD;
            end
         end
         default: begin
            state_in = cscan_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/cscan_dpath.sv =====
// Datapath: sorted request store, pointers, seek accumulator, result register.
`default_nettype none

module cscan_dpath #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_cmd,
   input  wire logic [TRACK_BITS-1:0]    req_track,
   input  wire logic [TRACK_BITS-1:0]    req_head_start,
   input  wire logic                     req_go_right,
   cscan_rsp_if.source                   rsp_chan,
   cscan_csr_if.sink                     csr_chan,
   input  wire cscan_pkg::dp_cmd_type    dp_cmd,
   output cscan_pkg::dp_status_type      status
);

   localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W   = cscan_pkg::COUNT_W;
   localparam int SEEK_W  = cscan_pkg::SEEK_W;
   localparam int CFG_W   = cscan_pkg::CFG_W;
   localparam int CLAMP_W = (TRACK_BITS + 1 > CFG_W) ? TRACK_BITS + 1 : CFG_W;
   localparam int TOP     = 2 ** TRACK_BITS;

   // registers
   logic [CFG_W-1:0]      disk_tracks_ff, disk_tracks_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [TRACK_BITS-1:0] track_ff, track_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic [TRACK_BITS-1:0] lastt_ff, lastt_in;
   logic                  dir_ff, dir_in;
   logic [SEEK_W-1:0]     seek_ff, seek_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRACK_BITS-1:0] rsp_track_ff, rsp_track_in;
   logic                  rsp_end_ff, rsp_end_in;
   logic [SEEK_W-1:0]     rsp_seek_ff, rsp_seek_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   // store access
   logic                  wr_en, rd_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [TRACK_BITS-1:0] wr_data, rd_data;

   logic [CNT_W-1:0]      ptr_m1, ptr_m2, ptr_p1;
   logic [CLAMP_W-1:0]    tracks_wide;
   logic [TRACK_BITS-1:0] lastt_calc;
   logic                  is_visit;
   logic [TRACK_BITS-1:0] target, move_dist;
   logic [SEEK_W:0]       seek_sum;
   logic [SEEK_W-1:0]     seek_next;

   cscan_ram #(
      .WIDTH (TRACK_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ptr_m1 = ptr_ff - CNT_W'(1);
   assign ptr_m2 = ptr_ff - CNT_W'(2);
   assign ptr_p1 = ptr_ff + CNT_W'(1);

   // last track = disk_tracks - 1, clamped to [1, 2^TRACK_BITS - 1]
   assign tracks_wide = CLAMP_W'(disk_tracks_ff);
   always_comb begin
      if (tracks_wide < CLAMP_W'(2)) begin
         lastt_calc = TRACK_BITS'(1);
      end else if (tracks_wide > CLAMP_W'(TOP)) begin
         lastt_calc = '1;
      end else begin
         lastt_calc = TRACK_BITS'(tracks_wide - CLAMP_W'(1));
      end
   end

   assign is_visit = (dp_cmd.op == cscan_pkg::DP_VISIT_REQ)  ||
                     (dp_cmd.op == cscan_pkg::DP_VISIT_END1) ||
                     (dp_cmd.op == cscan_pkg::DP_VISIT_END2);

   always_comb begin
      case (dp_cmd.op)
         cscan_pkg::DP_VISIT_END1: target = dir_ff ? lastt_ff : '0;
         cscan_pkg::DP_VISIT_END2: target = dir_ff ? '0 : lastt_ff;
         default:                  target = rd_data;
      endcase
   end

   assign move_dist = (head_ff > target) ? (head_ff - target) : (target - head_ff);
   assign seek_sum  = {1'b0, seek_ff} + {{(SEEK_W + 1 - TRACK_BITS){1'b0}}, move_dist};
   assign seek_next = seek_sum[SEEK_W] ? '1 : seek_sum[SEEK_W-1:0];

   // store port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[IDX_W-1:0];
      wr_data = track_ff;
      rd_en   = 1'b0;
      rd_addr = ptr_ff[IDX_W-1:0];
      case (dp_cmd.op)
         cscan_pkg::DP_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[IDX_W-1:0];
         end
         cscan_pkg::DP_INS_SHIFT: begin
            // move entry p-1 up to p and fetch entry p-2 in the same cycle
            wr_en   = 1'b1;
            wr_data = rd_data;
            rd_en   = (ptr_ff != CNT_W'(1));
            rd_addr = ptr_m2[IDX_W-1:0];
         end
         cscan_pkg::DP_INS_PLACE: begin
            wr_en = 1'b1;
         end
         cscan_pkg::DP_SCAN_FIRST, cscan_pkg::DP_SEG_READ: begin
            rd_en = 1'b1;
         end
         cscan_pkg::DP_SCAN_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_p1[IDX_W-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      disk_tracks_in = disk_tracks_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      mid_in         = mid_ff;
      left_in        = left_ff;
      track_in       = track_ff;
      head_in        = head_ff;
      lastt_in       = lastt_ff;
      dir_in         = dir_ff;
      seek_in        = seek_ff;

      if (csr_chan.valid) begin
         disk_tracks_in = csr_chan.wdata;
      end

      case (dp_cmd.op)
         cscan_pkg::DP_LATCH: begin
            track_in = req_track;
            head_in  = req_head_start;
            dir_in   = req_go_right;
            lastt_in = lastt_calc;
            seek_in  = '0;
            ptr_in   = (req_cmd == cscan_pkg::CMD_RUN) ? '0 : cnt_ff;
         end
         cscan_pkg::DP_INS_SHIFT: begin
            ptr_in = ptr_m1;
         end
         cscan_pkg::DP_INS_PLACE: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         cscan_pkg::DP_SCAN_NEXT: begin
            ptr_in = ptr_p1;
         end
         cscan_pkg::DP_MID_PTR: begin
            mid_in = ptr_ff;
         end
         cscan_pkg::DP_MID_N: begin
            mid_in = cnt_ff;
         end
         cscan_pkg::DP_SEG1_SETUP: begin
            ptr_in  = dir_ff ? mid_ff : (mid_ff - CNT_W'(1));
            left_in = dir_ff ? (cnt_ff - mid_ff) : mid_ff;
         end
         cscan_pkg::DP_VISIT_REQ: begin
            ptr_in  = dir_ff ? ptr_p1 : ptr_m1;
            left_in = left_ff - CNT_W'(1);
         end
         cscan_pkg::DP_VISIT_END2: begin
            // second segment wraps to the opposite end of the store
            ptr_in  = dir_ff ? '0 : (cnt_ff - CNT_W'(1));
            left_in = dir_ff ? mid_ff : (cnt_ff - mid_ff);
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase

      if (is_visit) begin
         seek_in = seek_next;
         head_in = target;
         if (dp_cmd.last) begin
            cnt_in = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_track_in = rsp_track_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (is_visit) begin
         rsp_valid_in = 1'b1;
         rsp_track_in = target;
         rsp_end_in   = (dp_cmd.op != cscan_pkg::DP_VISIT_REQ);
         rsp_seek_in  = seek_next;
         rsp_count_in = cnt_ff;
         rsp_last_in  = dp_cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_tracks_ff <= cscan_pkg::DISK_TRACKS_RESET;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         disk_tracks_ff <= disk_tracks_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      mid_ff       <= mid_in;
      left_ff      <= left_in;
      track_ff     <= track_in;
      head_ff      <= head_in;
      lastt_ff     <= lastt_in;
      dir_ff       <= dir_in;
      seek_ff      <= seek_in;
      rsp_track_ff <= rsp_track_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.served_track   = rsp_track_ff;
   assign rsp_chan.is_end_track   = rsp_end_ff;
   assign rsp_chan.seek_total     = rsp_seek_ff;
   assign rsp_chan.request_count  = rsp_count_ff;
   assign rsp_chan.last           = rsp_last_ff;

   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.cnt_full   = (cnt_ff == CNT_W'(MAX_REQUESTS));
   assign status.ins_gt     = (rd_data > track_ff);
   assign status.ptr_one    = (ptr_ff == CNT_W'(1));
   assign status.scan_gt    = (rd_data > head_ff);
   assign status.scan_end   = (ptr_p1 == cnt_ff);
   assign status.left_zero  = (left_ff == '0);
   assign status.left_one   = (left_ff == CNT_W'(1));
   assign status.seg2_empty = dir_ff ? (mid_ff == '0) : (mid_ff == cnt_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_REQUESTS))
      else $error("stored count above capacity");

   a_visit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      is_visit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten before transfer");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (is_visit && dp_cmd.last) |=> (cnt_ff == '0))
      else $error("store not emptied after final result");

endmodule

`default_nettype wire

// ===== test/cscan_disk_request_scheduler_unit_test.sv =====
// Self-checking testbench for the C-SCAN disk request scheduler.
module cscan_disk_request_scheduler_unit_test;

   localparam int MAX_REQ      = 32;
   localparam int TRK_W        = 10;
   localparam int SETTLE_TICKS = 60;
   localparam int PHASE_ITEMS  = 20;

   // Predicts the visit order of each run and checks visits as they arrive.
   class cscan_scoreboard;
      typedef struct packed {
         logic [TRK_W-1:0]              track;
         logic                          end_track;
         logic [cscan_pkg::SEEK_W-1:0]  seek;
         logic [cscan_pkg::COUNT_W-1:0] count;
         logic                          fin;
      } visit_type;

      logic [TRK_W-1:0]            sorted_tracks[$];
      logic [cscan_pkg::CFG_W-1:0] disk_tracks;
      visit_type                   visits_due[$];
      int                          errors;

      function new();
         disk_tracks = cscan_pkg::DISK_TRACKS_RESET;
         errors      = 0;
      endfunction

      function void set_tracks(logic [cscan_pkg::CFG_W-1:0] value);
         disk_tracks = value;
      endfunction

      function int last_track();
         int dt;
         dt = int'(disk_tracks);
         if (dt < 2) dt = 2;
         if (dt > (1 << TRK_W)) dt = 1 << TRK_W;
         return dt - 1;
      endfunction

      function void note_request(logic cmd, logic [TRK_W-1:0] trk, logic [TRK_W-1:0] head,
                                 logic right);
         int         n, mid, lastt, pos, seek, idx, i;
         int         order[$];
         bit         at_end[$];
         visit_type  v;
         if (cmd == cscan_pkg::CMD_LOAD) begin
            // a full store drops the request
            if (sorted_tracks.size() < MAX_REQ) begin
               idx = 0;
               while (idx < sorted_tracks.size() && sorted_tracks[idx] <= trk) idx++;
               sorted_tracks.insert(idx, trk);
            end
            return;
         end
         n     = sorted_tracks.size();
         lastt = last_track();
         mid   = n;
         for (i = n - 1; i >= 0; i--)
            if (sorted_tracks[i] > head) mid = i;
         if (right) begin
            for (i = mid; i < n; i++) begin
               order.push_back(int'(sorted_tracks[i])); at_end.push_back(1'b0);
            end
            order.push_back(lastt); at_end.push_back(1'b1);
            order.push_back(0);     at_end.push_back(1'b1);
            for (i = 0; i < mid; i++) begin
               order.push_back(int'(sorted_tracks[i])); at_end.push_back(1'b0);
            end
         end else begin
            for (i = mid - 1; i >= 0; i--) begin
               order.push_back(int'(sorted_tracks[i])); at_end.push_back(1'b0);
            end
            order.push_back(0);     at_end.push_back(1'b1);
            order.push_back(lastt); at_end.push_back(1'b1);
            for (i = n - 1; i >= mid; i--) begin
               order.push_back(int'(sorted_tracks[i])); at_end.push_back(1'b0);
            end
         end
         // the wrap jump is just the distance between the two end tracks
         pos  = int'(head);
         seek = 0;
         for (i = 0; i < order.size(); i++) begin
            seek += (pos > order[i]) ? pos - order[i] : order[i] - pos;
            if (seek > 65535) seek = 65535;
            pos         = order[i];
            v.track     = TRK_W'(order[i]);
            v.end_track = at_end[i];
            v.seek      = cscan_pkg::SEEK_W'(seek);
            v.count     = cscan_pkg::COUNT_W'(n);
            v.fin       = (i == order.size() - 1);
            visits_due.push_back(v);
         end
         sorted_tracks.delete();
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 100) $display("mismatch: %s", msg);
      endtask

      task check_visit(logic [TRK_W-1:0] trk, logic end_t,
                       logic [cscan_pkg::SEEK_W-1:0] seek,
                       logic [cscan_pkg::COUNT_W-1:0] cnt, logic fin);
         visit_type want;
         if (visits_due.size() == 0) begin
            report_mismatch($sformatf("unexpected visit to track %0d", trk));
            return;
         end
         want = visits_due.pop_front();
         if (trk !== want.track)
            report_mismatch($sformatf("served_track %0d, want %0d", trk, want.track));
         if (end_t !== want.end_track)
            report_mismatch($sformatf("is_end_track %0b, want %0b at track %0d",
                                      end_t, want.end_track, want.track));
         if (seek !== want.seek)
            report_mismatch($sformatf("seek_total %0d, want %0d at track %0d",
                                      seek, want.seek, want.track));
         if (cnt !== want.count)
            report_mismatch($sformatf("request_count %0d, want %0d", cnt, want.count));
         if (fin !== want.fin)
            report_mismatch($sformatf("last %0b, want %0b at track %0d",
                                      fin, want.fin, want.track));
      endtask
   endclass

   logic clock;
   logic reset;
   int   tx_idle;
   int   rx_idle;
   int   items_sent;

   cscan_scoreboard sb;

   cscan_req_if #(.TRACK_BITS(TRK_W)) req_chan();
   cscan_rsp_if #(.TRACK_BITS(TRK_W)) rsp_chan();
   cscan_csr_if                       csr_chan();

   cscan_disk_request_scheduler_unit #(
      .MAX_REQUESTS(MAX_REQ),
      .TRACK_BITS  (TRK_W)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (rx_idle == 0) rsp_chan.ready <= 1'b1;
      else rsp_chan.ready <= ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_visit(rsp_chan.served_track, rsp_chan.is_end_track, rsp_chan.seek_total,
                        rsp_chan.request_count, rsp_chan.last);
   end

   task automatic send_req(logic cmd, logic [TRK_W-1:0] trk, logic [TRK_W-1:0] head,
                           logic right);
      if (tx_idle > 0)
         while ($urandom_range(99) < tx_idle) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.track      <= trk;
      req_chan.head_start <= head;
      req_chan.go_right   <= right;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(cmd, trk, head, right);
   endtask

   task automatic write_tracks(logic [cscan_pkg::CFG_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.wdata <= value;
      do @(posedge clock); while (!csr_chan.ready);
      sb.set_tracks(value);
      csr_chan.valid <= 1'b0;
   endtask

   // wait out every pending visit plus the longest silent load
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.visits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // one batch of loads followed by a run; some batches overfill the store
   task automatic load_and_run();
      int               n_loads, hi, pick, k;
      logic [TRK_W-1:0] trk, head;
      logic [TRK_W-1:0] loaded[$];
      pick = $urandom_range(99);
      if (pick < 8) n_loads = 0;
      else if (pick < 18) n_loads = $urandom_range(36, 30);
      else n_loads = $urandom_range(12, 1);
      hi = sb.last_track();
      for (k = 0; k < n_loads; k++) begin
         pick = $urandom_range(9);
         if (pick == 0) trk = TRK_W'($urandom_range(1023));
         else if (pick == 1 && loaded.size() > 0) trk = loaded[$urandom_range(loaded.size() - 1)];
         else trk = TRK_W'($urandom_range(hi));
         loaded.push_back(trk);
         send_req(cscan_pkg::CMD_LOAD, trk, TRK_W'($urandom_range(1023)),
                  1'($urandom_range(1)));
         if (k < MAX_REQ) items_sent++;
      end
      pick = $urandom_range(9);
      if (pick < 3 && loaded.size() > 0) head = loaded[$urandom_range(loaded.size() - 1)];
      else if (pick == 3) head = '0;
      else if (pick == 4) head = TRK_W'(hi);
      else if (pick == 5) head = TRK_W'($urandom_range(1023));
      else head = TRK_W'($urandom_range(hi));
      send_req(cscan_pkg::CMD_RUN, TRK_W'($urandom_range(1023)), head, 1'($urandom_range(1)));
      items_sent++;
   endtask

   initial begin
      logic [cscan_pkg::CFG_W-1:0] track_plan[9];
      int                          phase;
      track_plan = '{11'd1024, 11'd2, 11'd0, 11'd2047, 11'd1025, 11'd1, 11'd600, 11'd16,
                     11'd333};
      sb                  = new();
      reset               = 1'b1;
      tx_idle             = 15;
      rx_idle             = 87;
      items_sent          = 0;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = cscan_pkg::CMD_LOAD;
      req_chan.track      = '0;
      req_chan.head_start = '0;
      req_chan.go_right   = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.wdata      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset track count: unsorted loads, one beyond the last track
      send_req(cscan_pkg::CMD_LOAD, 10'd50, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd0, 10'd1023, 1'b1);
      send_req(cscan_pkg::CMD_LOAD, 10'd199, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd1023, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd150, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd100, 1'b1);
      // empty store, both directions
      send_req(cscan_pkg::CMD_RUN, 10'd1023, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd1023, 1'b1);
      // nothing above the head
      send_req(cscan_pkg::CMD_LOAD, 10'd10, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd20, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd20, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd1023, 1'b1);
      // head equal to requests, going left
      send_req(cscan_pkg::CMD_LOAD, 10'd5, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd5, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd30, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd5, 1'b0);
      // both extremes, head at zero going left
      send_req(cscan_pkg::CMD_LOAD, 10'd1023, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd0, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_LOAD, 10'd512, 10'd0, 1'b0);
      send_req(cscan_pkg::CMD_RUN, 10'd0, 10'd511, 1'b1);
      drain();

      for (phase = 0; phase < 9; phase++) begin
         tx_idle = (phase < 3) ? 15 : (phase < 6) ? 87 : 0;
         rx_idle = (phase < 3) ? 87 : (phase < 6) ? 15 : 0;
         write_tracks(track_plan[phase]);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) load_and_run();
         drain();
      end

      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
